[rtl/bps_pkg.sv]
// Shared types, constants and saturation helpers for the bouncing particle stepper.
package bps_pkg;

    localparam int AXES   = 3;
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef logic signed [31:0] t_q16;
    typedef t_q16 [AXES-1:0]    t_vec;
    typedef logic [63:0]        t_sq;
    typedef t_sq [AXES-1:0]     t_sq_vec;

    // Input item modes
    localparam logic MODE_LAUNCH = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_ACCEL_X     = 3'd0;
    localparam logic [2:0] CFG_ACCEL_Y     = 3'd1;
    localparam logic [2:0] CFG_ACCEL_Z     = 3'd2;
    localparam logic [2:0] CFG_RESTITUTION = 3'd3;
    localparam logic [2:0] CFG_RADIUS      = 3'd4;
    localparam logic [2:0] CFG_REST_SPEED  = 3'd5;

    // Reset values of the configuration registers
    localparam t_q16        RST_ACCEL_X     = 32'sd0;
    localparam t_q16        RST_ACCEL_Y     = -32'sd642908;
    localparam t_q16        RST_ACCEL_Z     = 32'sd0;
    localparam logic [16:0] RST_RESTITUTION = 17'd52429;
    localparam logic [30:0] RST_RADIUS      = 31'd65536;
    localparam logic [30:0] RST_REST_SPEED  = 31'd32768;

    localparam t_q16 Q16_MAX = 32'sh7fff_ffff;
    localparam t_q16 Q16_MIN = 32'sh8000_0000;

    // Result of the merge stage: new ball state plus flags
    typedef struct packed {
        logic bounced;
        logic moving;
        t_vec pos;
        t_vec vel;
    } t_merge;

    function automatic t_q16 sat33(input logic signed [32:0] x);
        t_q16 r;
        if (x[32] != x[31]) begin
            r = x[32] ? Q16_MIN : Q16_MAX;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic t_q16 sat34(input logic signed [33:0] x);
        t_q16 r;
        if ((x[33] == x[32]) && (x[32] == x[31])) begin
            r = x[31:0];
        end else begin
            r = x[33] ? Q16_MIN : Q16_MAX;
        end
        return r;
    endfunction

endpackage

[rtl/bps_lane.sv]
// One axis lane: constant-acceleration update of position and velocity, and speed square.
module bps_lane import bps_pkg::*; (
    input  logic        i_clk,
    input  t_q16        i_pos,
    input  t_q16        i_vel,
    input  t_q16        i_acc,
    input  logic [15:0] i_dt,
    output t_q16        o_pos_new,
    output t_q16        o_vel_new,
    output t_sq         o_vel_sq
);

    logic signed [16:0] w_dt;
    logic signed [48:0] r_vdt_prod;
    logic signed [48:0] r_adt_prod;
    t_q16               w_adt;
    t_q16               r_vdt;
    logic signed [48:0] r_half_prod;
    t_q16               r_vel_new;
    t_q16               r_pos_new;
    t_q16               w_half;
    logic signed [33:0] w_pos_sum;
    logic [31:0]        w_vel_mag;
    t_sq                r_vel_sq;

    assign w_dt  = $signed({1'b0, i_dt});
    // floor(x / 2^16): arithmetic shift, value fits in 32 bits
    assign w_adt = r_adt_prod[47:16];
    // floor(adt*dt / 2^17)
    assign w_half = r_half_prod[48:17];
    assign w_pos_sum = {{2{i_pos[31]}}, i_pos} + {{2{r_vdt[31]}}, r_vdt}
                     + {{2{w_half[31]}}, w_half};
    assign w_vel_mag = r_vel_new[31] ? (32'd0 - r_vel_new) : r_vel_new;

    // Stage 1: v*dt and a*dt
    always_ff @(posedge i_clk) begin
        r_vdt_prod <= i_vel * w_dt;
        r_adt_prod <= i_acc * w_dt;
    end

    // Stage 2: adt*dt, new velocity
    always_ff @(posedge i_clk) begin
        r_half_prod <= w_adt * w_dt;
        r_vdt       <= r_vdt_prod[47:16];
        r_vel_new   <= sat33({i_vel[31], i_vel} + {w_adt[31], w_adt});
    end

    // Stage 3: new position, square of new velocity
    always_ff @(posedge i_clk) begin
        r_pos_new <= sat34(w_pos_sum);
        r_vel_sq  <= w_vel_mag * w_vel_mag;
    end

    assign o_pos_new = r_pos_new;
    assign o_vel_new = r_vel_new;
    assign o_vel_sq  = r_vel_sq;

endmodule

[rtl/bps_merge.sv]
// Merge of the lane results: plane test, squared speed compare, bounce or rest.
module bps_merge import bps_pkg::*; (
    input  logic        i_clk,
    input  t_vec        i_pos_new,
    input  t_vec        i_vel_new,
    input  t_sq_vec     i_vel_sq,
    input  logic [16:0] i_restitution,
    input  logic [30:0] i_radius,
    input  logic [30:0] i_rest_speed,
    output t_merge      o_result
);

    logic [61:0]        r_th2;
    t_q16               r_vel_bounce;
    logic [31:0]        w_up_mag;
    logic [48:0]        w_bounce_prod;
    logic [32:0]        w_bounce_shift;
    logic signed [32:0] w_floor_diff;
    logic [65:0]        w_speed_sq;
    logic               w_collide;
    logic               w_fast;

    // Magnitude of a falling y velocity, exact up to 2^31
    assign w_up_mag       = 32'd0 - i_vel_new[AXIS_Y];
    assign w_bounce_prod  = w_up_mag * i_restitution;
    assign w_bounce_shift = w_bounce_prod[48:16];

    always_ff @(posedge i_clk) begin
        r_th2 <= i_rest_speed * i_rest_speed;
        if (w_bounce_shift > {1'b0, Q16_MAX}) begin
            r_vel_bounce <= Q16_MAX;
        end else begin
            r_vel_bounce <= w_bounce_shift[31:0];
        end
    end

    assign w_floor_diff = {i_pos_new[AXIS_Y][31], i_pos_new[AXIS_Y]}
                        - $signed({2'b00, i_radius});
    assign w_collide = w_floor_diff[32] && i_vel_new[AXIS_Y][31];

    always_comb begin
        w_speed_sq = '0;
        for (int i = 0; i < AXES; i++) begin
            w_speed_sq = w_speed_sq + {2'b00, i_vel_sq[i]};
        end
    end

    assign w_fast = w_speed_sq > {4'd0, r_th2};

    always_comb begin
        o_result.bounced = w_collide;
        o_result.moving  = 1'b1;
        o_result.pos     = i_pos_new;
        o_result.vel     = i_vel_new;
        if (w_collide) begin
            if (w_fast) begin
                o_result.vel[AXIS_Y] = r_vel_bounce;
            end else begin
                o_result.vel         = '0;
                o_result.pos[AXIS_Y] = {1'b0, i_radius};
                o_result.moving      = 1'b0;
            end
        end
    end

endmodule

[rtl/bouncing_particle_step_core.sv]
// Top level of the bouncing particle stepper: control, ball state, registers and result.
// Keeps one ball (Q16.16 position and velocity, an active flag) and gives one result per
// input transfer. A launch (mode 0) loads position and velocity and marks the ball active;
// a tick (mode 1) advances an active ball by step_time under the configured acceleration,
// then tests it against the plane y = 0 and either bounces it (y velocity reversed and
// scaled by restitution) or brings it to rest on the plane. A launch, or a tick of a ball
// at rest, reaches the result register through the DONE state; a tick of an active ball
// goes through C1, C2, C3 and WB, set by the chain of dependent multiplies in each axis
// lane (v*dt and a*dt, then adt*dt, then the speed square) followed by the merge compare.
// One item is in work at a time; the next input transfer is taken the cycle after the
// result is loaded, even while that result still waits for its output transfer.
// Configuration writes are taken at any cycle (o_cfg_ready is always high) and must be
// made while the block is idle; indexes beyond the register list are dropped.
module bouncing_particle_step_core import bps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [15:0] i_step_time,
    input  t_q16        i_start_x,
    input  t_q16        i_start_y,
    input  t_q16        i_start_z,
    input  t_q16        i_start_vx,
    input  t_q16        i_start_vy,
    input  t_q16        i_start_vz,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_bounced,
    output logic        o_moving,
    output t_q16        o_now_x,
    output t_q16        o_now_y,
    output t_q16        o_now_z,
    output t_q16        o_now_vx,
    output t_q16        o_now_vy,
    output t_q16        o_now_vz
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_C1   = 3'd1;
    localparam logic [2:0] ST_C2   = 3'd2;
    localparam logic [2:0] ST_C3   = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // configuration registers
    t_vec        r_accel;
    logic [16:0] r_restitution;
    logic [30:0] r_radius;
    logic [30:0] r_rest_speed;

    // ball state
    t_vec        r_pos;
    t_vec        r_vel;
    logic        r_moving;
    logic [15:0] r_dt;

    logic [2:0]  r_state;
    logic [2:0]  n_state;

    // result register
    logic        r_out_valid;
    t_merge      r_out;

    t_vec        w_pos_new;
    t_vec        w_vel_new;
    t_sq_vec     w_vel_sq;
    t_merge      w_merge;
    logic        w_in_xfer;
    logic        w_out_free;
    logic        w_load_merge;
    logic        w_load_held;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    // result register can take a new value this cycle
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_load_merge = (r_state == ST_WB) && w_out_free;
    assign w_load_held  = (r_state == ST_DONE) && w_out_free;

    // ---------------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel[AXIS_X] <= RST_ACCEL_X;
            r_accel[AXIS_Y] <= RST_ACCEL_Y;
            r_accel[AXIS_Z] <= RST_ACCEL_Z;
            r_restitution   <= RST_RESTITUTION;
            r_radius        <= RST_RADIUS;
            r_rest_speed    <= RST_REST_SPEED;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACCEL_X:     r_accel[AXIS_X] <= i_cfg_data;
                CFG_ACCEL_Y:     r_accel[AXIS_Y] <= i_cfg_data;
                CFG_ACCEL_Z:     r_accel[AXIS_Z] <= i_cfg_data;
                CFG_RESTITUTION: r_restitution   <= i_cfg_data[16:0];
                CFG_RADIUS:      r_radius        <= i_cfg_data[30:0];
                CFG_REST_SPEED:  r_rest_speed    <= i_cfg_data[30:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Axis lanes and merge. The lanes run freely off the held ball state and step time;
    // the sequencer below only decides when their results are valid.
    // ---------------------------------------------------------------------------------
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        bps_lane u_lane (
            .i_clk     (i_clk),
            .i_pos     (r_pos[g]),
            .i_vel     (r_vel[g]),
            .i_acc     (r_accel[g]),
            .i_dt      (r_dt),
            .o_pos_new (w_pos_new[g]),
            .o_vel_new (w_vel_new[g]),
            .o_vel_sq  (w_vel_sq[g])
        );
    end

    bps_merge u_merge (
        .i_clk         (i_clk),
        .i_pos_new     (w_pos_new),
        .i_vel_new     (w_vel_new),
        .i_vel_sq      (w_vel_sq),
        .i_restitution (r_restitution),
        .i_radius      (r_radius),
        .i_rest_speed  (r_rest_speed),
        .o_result      (w_merge)
    );

    // ---------------------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    // launch and ticks of a resting ball only report the held state
                    if ((i_mode == MODE_LAUNCH) || !r_moving) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_C1;
                    end
                end
            end
            ST_C1:   n_state = ST_C2;
            ST_C2:   n_state = ST_C3;
            ST_C3:   n_state = ST_WB;
            ST_WB:   if (w_out_free) n_state = ST_IDLE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------------------------
    // Ball state: load on launch, write back the merge result at the end of a tick
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_vel    <= '0;
            r_moving <= 1'b0;
        end else if (w_in_xfer && (i_mode == MODE_LAUNCH)) begin
            r_pos[AXIS_X] <= i_start_x;
            r_pos[AXIS_Y] <= i_start_y;
            r_pos[AXIS_Z] <= i_start_z;
            r_vel[AXIS_X] <= i_start_vx;
            r_vel[AXIS_Y] <= i_start_vy;
            r_vel[AXIS_Z] <= i_start_vz;
            r_moving      <= 1'b1;
        end else if (w_load_merge) begin
            r_pos    <= w_merge.pos;
            r_vel    <= w_merge.vel;
            r_moving <= w_merge.moving;
        end
    end

    // hold the step time for the lanes through the whole tick
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_dt <= i_step_time;
        end
    end

    // ---------------------------------------------------------------------------------
    // Result register: parts the result transfer from the next input transfer
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_merge || w_load_held) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_merge) begin
            r_out <= w_merge;
        end else if (w_load_held) begin
            r_out.bounced <= 1'b0;
            r_out.moving  <= r_moving;
            r_out.pos     <= r_pos;
            r_out.vel     <= r_vel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bounced   = r_out.bounced;
    assign o_moving    = r_out.moving;
    assign o_now_x     = r_out.pos[AXIS_X];
    assign o_now_y     = r_out.pos[AXIS_Y];
    assign o_now_z     = r_out.pos[AXIS_Z];
    assign o_now_vx    = r_out.vel[AXIS_X];
    assign o_now_vy    = r_out.vel[AXIS_Y];
    assign o_now_vz    = r_out.vel[AXIS_Z];

`ifndef ASSERT_OFF
    // a ball that came to rest on the plane reports zero velocity
    a_rest_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bounced && !o_moving |->
            (o_now_vx == 32'sd0) && (o_now_vy == 32'sd0) && (o_now_vz == 32'sd0))
        else $error("resting ball reports nonzero velocity");

    // a bounce that keeps the ball moving sends it upward
    a_bounce_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bounced && o_moving |-> !o_now_vy[31])
        else $error("bounced ball still falls");

    // the lane pipeline advances one stage per cycle without stalling
    a_lane_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_C1) |=> (r_state == ST_C2) ##1 (r_state == ST_C3)
            ##1 (r_state == ST_WB))
        else $error("tick sequencer skipped a lane stage");
`endif

endmodule
